@@ sv/gir_pkg.sv @@
// ----------------------------------------------------------------------------
// Generation interval registry - shared types
// Field widths, operation and match codes, and the generation slot layout.
// ----------------------------------------------------------------------------
package gir_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned GEN_W = 32;
  localparam int unsigned TS_W  = 63;
  localparam int unsigned MT_W  = 7;
  localparam int unsigned CNT_W = 7;

  typedef enum logic {
    OP_OBSERVE   = 1'b0,
    OP_CORRELATE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    MATCH_CURRENT    = 2'd0,
    MATCH_SUPERSEDED = 2'd1,
    MATCH_UNKNOWN    = 2'd2,
    MATCH_NO_RECORD  = 2'd3
  } match_e;

  // one generation window as held in the slot memory
  typedef struct packed {
    logic             valid;
    logic [GEN_W-1:0] gen;
    logic [TS_W-1:0]  first;
    logic [TS_W-1:0]  last;
  } slot_t;

endpackage

@@ sv/generation_interval_registry_unit.sv @@
// ----------------------------------------------------------------------------
// Generation interval registry
// Tracks generation windows per flow and per path and answers which
// generation was current for an entity at a given instant.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; busy_o stays high
// until the command is finished. An observe command gives no result. A
// correlate command gives one result, shown for exactly one cycle with
// result_valid_o high; the receiver cannot stall it, so it must take it then.
// Every command first walks the whole entity table of the selected side
// through the key memory, one entry per cycle, then walks the entity's
// GENS_PER_ENTITY slots in the slot memory and finishes with a write or a
// result state. A new entity adds an allocation step and a pass that clears
// its GENS_PER_ENTITY slots; a correlate for an unknown entity ends after
// the entity walk. The next command can be taken in the first cycle with
// busy_o low. No clearing pass is needed after reset: entity valid bits live
// in flops and slots are cleared whenever an entity is allocated.
// max_tracked is written over the cfg channel, which is ready only while the
// block is idle and no command is offered.
// ----------------------------------------------------------------------------
module generation_interval_registry_unit
  import gir_pkg::*;
#(
  parameter int unsigned ENTITY_SLOTS    = 64,
  parameter int unsigned GENS_PER_ENTITY = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command
  input  logic              start_i,
  output logic              busy_o,
  input  logic              opcode_i,
  input  logic              table_select_i,
  input  logic [KEY_W-1:0]  entity_id_i,
  input  logic [GEN_W-1:0]  generation_id_i,
  input  logic [TS_W-1:0]   time_stamp_i,
  // result
  output logic              result_valid_o,
  output logic [1:0]        match_code_o,
  output logic [GEN_W-1:0]  current_generation_o,
  output logic [TS_W-1:0]   active_since_o,
  output logic              gen_superseded_o,
  output logic [CNT_W-1:0]  tracked_count_o,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [MT_W-1:0]   cfg_data_i
);

  // sizes
  localparam int unsigned NUM_ENT   = 2 * ENTITY_SLOTS;
  localparam int unsigned NUM_SLOTS = NUM_ENT * GENS_PER_ENTITY;
  localparam int unsigned EW   = $clog2(NUM_ENT);                          // entity address
  localparam int unsigned EIW  = (ENTITY_SLOTS > 1) ? $clog2(ENTITY_SLOTS) : 1;
  localparam int unsigned ECW  = $clog2(ENTITY_SLOTS + 1);                // walk counter
  localparam int unsigned CW   = $clog2(ENTITY_SLOTS + 1);                // entity count
  localparam int unsigned SAW  = $clog2(NUM_SLOTS);                        // slot address
  localparam int unsigned GIW  = (GENS_PER_ENTITY > 1) ? $clog2(GENS_PER_ENTITY) : 1;
  localparam int unsigned GCW  = $clog2(GENS_PER_ENTITY + 1);
  localparam int unsigned SW   = $bits(slot_t);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EFIND = 7'b0000010,
    S_EADD  = 7'b0000100,
    S_CLR   = 7'b0001000,
    S_SSCAN = 7'b0010000,
    S_SWR   = 7'b0100000,
    S_RES   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [MT_W-1:0]  mt_q;
  logic [NUM_ENT-1:0] ev_q;
  logic [CW-1:0]    cnt_q [2];

  // captured command
  logic             op_q, t_q;
  logic [KEY_W-1:0] key_q;
  logic [GEN_W-1:0] gen_q;
  logic [TS_W-1:0]  ts_q;

  // entity walk
  logic [ECW-1:0]   ecnt_q;
  logic             epend_q;
  logic [EIW-1:0]   eidx_q;
  logic             efound_q, emin_v_q, efree_v_q;
  logic [EIW-1:0]   efound_idx_q, emin_idx_q, efree_idx_q;
  logic [KEY_W-1:0] emin_key_q;
  logic [EW-1:0]    ent_q;

  // slot walk
  logic [GCW-1:0]   gcnt_q;
  logic             spend_q;
  logic [GIW-1:0]   sidx_q;
  logic             sm_v_q, sf_v_q, sl_v_q;
  logic [GIW-1:0]   sm_idx_q, sf_idx_q, sl_idx_q;
  logic [TS_W-1:0]  sm_first_q, sm_last_q;
  logic [GEN_W-1:0] sl_gen_q;
  logic             c_any_q, c_have_q, c_cov_q;
  logic [GEN_W-1:0] c_best_q;
  logic [TS_W-1:0]  c_first_q;

  // result
  match_e           res_code_q;
  logic [GEN_W-1:0] res_gen_q;
  logic [TS_W-1:0]  res_since_q;
  logic             res_chg_q;
  logic [CNT_W-1:0] res_cnt_q;

  // memory ports
  logic             e_we;
  logic [EW-1:0]    e_waddr, e_raddr;
  logic [KEY_W-1:0] e_rdata;
  logic             s_we;
  logic [SAW-1:0]   s_waddr, s_raddr;
  slot_t            s_wdata, s_rd;
  logic [SW-1:0]    s_rdata;

  logic [EW-1:0]    ebase;
  logic [SAW-1:0]   sbase;
  logic             e_walk_done, s_walk_done;
  logic             e_cur_valid;
  logic             lim_hit, evict;
  logic [EIW-1:0]   pick_idx;
  logic [NUM_ENT-1:0] ev_set, ev_clr;
  logic [GIW-1:0]   s_pick;
  logic             cov, started, upd;

  gir_ram #(.WIDTH(KEY_W), .DEPTH(NUM_ENT)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (key_q),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  gir_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign s_rd = slot_t'(s_rdata);

  // address generation and datapath decisions
  always_comb begin
    ebase       = t_q ? EW'(ENTITY_SLOTS) : '0;
    sbase       = SAW'(SAW'(ent_q) * SAW'(GENS_PER_ENTITY));
    e_raddr     = ebase + EW'(ecnt_q[EIW-1:0]);
    s_raddr     = sbase + SAW'(gcnt_q[GIW-1:0]);
    e_walk_done = (ecnt_q == ECW'(ENTITY_SLOTS)) && !epend_q;
    s_walk_done = (gcnt_q == GCW'(GENS_PER_ENTITY)) && !spend_q;
    e_cur_valid = ev_q[ebase + EW'(eidx_q)];

    // out-of-range limits clamp to 1 and ENTITY_SLOTS
    if (mt_q == '0) begin
      lim_hit = (cnt_q[t_q] != '0);
    end else if (32'(mt_q) > ENTITY_SLOTS) begin
      lim_hit = (32'(cnt_q[t_q]) >= ENTITY_SLOTS);
    end else begin
      lim_hit = (32'(cnt_q[t_q]) >= 32'(mt_q));
    end
    evict = lim_hit && emin_v_q;

    if (evict && (!efree_v_q || (emin_idx_q < efree_idx_q))) begin
      pick_idx = emin_idx_q;
    end else if (efree_v_q) begin
      pick_idx = efree_idx_q;
    end else begin
      pick_idx = '0;
    end
    e_we    = (state_q == S_EADD);
    e_waddr = ebase + EW'(pick_idx);

    // valid bit update: evicted entry cleared, allocated entry set
    ev_set = '0;
    ev_set[ebase + EW'(pick_idx)] = 1'b1;
    ev_clr = '0;
    if (evict) begin
      ev_clr[ebase + EW'(emin_idx_q)] = 1'b1;
    end

    // slot to overwrite: first free, else lowest generation
    if (sf_v_q) begin
      s_pick = sf_idx_q;
    end else if (sl_v_q) begin
      s_pick = sl_idx_q;
    end else begin
      s_pick = '0;
    end

    s_we    = 1'b0;
    s_waddr = sbase + SAW'(gcnt_q[GIW-1:0]);
    s_wdata = '0;
    if (state_q == S_CLR) begin
      s_we = 1'b1;
    end else if (state_q == S_SWR) begin
      s_we          = 1'b1;
      s_wdata.valid = 1'b1;
      s_wdata.gen   = gen_q;
      if (sm_v_q) begin
        s_waddr       = sbase + SAW'(sm_idx_q);
        s_wdata.first = (ts_q < sm_first_q) ? ts_q : sm_first_q;
        s_wdata.last  = (ts_q > sm_last_q) ? ts_q : sm_last_q;
      end else begin
        s_waddr       = sbase + SAW'(s_pick);
        s_wdata.first = ts_q;
        s_wdata.last  = ts_q;
      end
    end

    // current-generation ranking: covering window, latest start, larger id
    cov     = (s_rd.last >= ts_q);
    started = (s_rd.first <= ts_q);
    upd     = !c_have_q || (cov && !c_cov_q) ||
              ((cov == c_cov_q) &&
               ((s_rd.first > c_first_q) ||
                ((s_rd.first == c_first_q) && (s_rd.gen > c_best_q))));
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) state_d = S_EFIND;
      S_EFIND: begin
        if (e_walk_done) begin
          if (efound_q) begin
            state_d = S_SSCAN;
          end else if (op_q == OP_CORRELATE) begin
            state_d = S_RES;
          end else begin
            state_d = S_EADD;
          end
        end
      end
      S_EADD:  state_d = S_CLR;
      S_CLR:   if (gcnt_q == GCW'(GENS_PER_ENTITY - 1)) state_d = S_SSCAN;
      S_SSCAN: begin
        if (s_walk_done) begin
          state_d = (op_q == OP_CORRELATE) ? S_RES : S_SWR;
        end
      end
      S_SWR:   state_d = S_IDLE;
      S_RES:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mt_q      <= MT_W'(64);
      ev_q      <= '0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      ecnt_q    <= '0;
      epend_q   <= 1'b0;
      efound_q  <= 1'b0;
      emin_v_q  <= 1'b0;
      efree_v_q <= 1'b0;
      gcnt_q    <= '0;
      spend_q   <= 1'b0;
      sm_v_q    <= 1'b0;
      sf_v_q    <= 1'b0;
      sl_v_q    <= 1'b0;
      c_any_q   <= 1'b0;
      c_have_q  <= 1'b0;
      c_cov_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mt_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          ecnt_q    <= '0;
          epend_q   <= 1'b0;
          efound_q  <= 1'b0;
          emin_v_q  <= 1'b0;
          efree_v_q <= 1'b0;
        end
        S_EFIND: begin
          if (ecnt_q != ECW'(ENTITY_SLOTS)) begin
            ecnt_q  <= ecnt_q + 1'b1;
            epend_q <= 1'b1;
          end else begin
            epend_q <= 1'b0;
          end
          if (epend_q) begin
            if (e_cur_valid && (e_rdata == key_q)) begin
              efound_q <= 1'b1;
            end
            if (e_cur_valid && (!emin_v_q || (e_rdata < emin_key_q))) begin
              emin_v_q <= 1'b1;
            end
            if (!e_cur_valid && !efree_v_q) begin
              efree_v_q <= 1'b1;
            end
          end
        end
        S_EADD: begin
          // evicted entity's slots are cleared when its entry is reused
          ev_q       <= (ev_q & ~ev_clr) | ev_set;
          cnt_q[t_q] <= cnt_q[t_q] - CW'(evict) + 1'b1;
          gcnt_q     <= '0;
        end
        S_CLR: begin
          // the last clear hands over to the slot walk, which restarts the count
          if (gcnt_q != GCW'(GENS_PER_ENTITY - 1)) begin
            gcnt_q <= gcnt_q + 1'b1;
          end
        end
        S_SSCAN: begin
          if (gcnt_q != GCW'(GENS_PER_ENTITY)) begin
            gcnt_q  <= gcnt_q + 1'b1;
            spend_q <= 1'b1;
          end else begin
            spend_q <= 1'b0;
          end
          if (spend_q && s_rd.valid) begin
            c_any_q <= 1'b1;
            if (s_rd.gen == gen_q) begin
              sm_v_q <= 1'b1;
            end
            if (!sf_v_q && (!sl_v_q || (s_rd.gen < sl_gen_q))) begin
              sl_v_q <= 1'b1;
            end
            if (started && upd) begin
              c_have_q <= 1'b1;
              c_cov_q  <= cov;
            end
          end
          if (spend_q && !s_rd.valid && !sf_v_q) begin
            sf_v_q <= 1'b1;
          end
        end
        S_SWR, S_RES: begin
        end
        default: begin
        end
      endcase
      // slot walk trackers start clean
      if ((state_d == S_SSCAN) && (state_q != S_SSCAN)) begin
        gcnt_q   <= '0;
        spend_q  <= 1'b0;
        sm_v_q   <= 1'b0;
        sf_v_q   <= 1'b0;
        sl_v_q   <= 1'b0;
        c_any_q  <= 1'b0;
        c_have_q <= 1'b0;
        c_cov_q  <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start_i) begin
      op_q      <= opcode_i;
      t_q       <= table_select_i;
      key_q     <= entity_id_i;
      gen_q     <= generation_id_i;
      ts_q      <= time_stamp_i;
      res_cnt_q <= CNT_W'(cnt_q[table_select_i]);
    end
    if (state_q == S_EFIND) begin
      eidx_q <= ecnt_q[EIW-1:0];
      if (epend_q) begin
        if (e_cur_valid && (e_rdata == key_q)) begin
          efound_idx_q <= eidx_q;
        end
        if (e_cur_valid && (!emin_v_q || (e_rdata < emin_key_q))) begin
          emin_key_q <= e_rdata;
          emin_idx_q <= eidx_q;
        end
        if (!e_cur_valid && !efree_v_q) begin
          efree_idx_q <= eidx_q;
        end
      end
      if (e_walk_done) begin
        ent_q       <= ebase + EW'(efound_idx_q);
        res_code_q  <= MATCH_NO_RECORD;
        res_gen_q   <= '0;
        res_since_q <= '0;
        res_chg_q   <= 1'b0;
      end
    end
    if (state_q == S_EADD) begin
      ent_q <= ebase + EW'(pick_idx);
    end
    if (state_q == S_SSCAN) begin
      sidx_q <= gcnt_q[GIW-1:0];
      if (spend_q && s_rd.valid) begin
        if (s_rd.gen == gen_q) begin
          sm_idx_q   <= sidx_q;
          sm_first_q <= s_rd.first;
          sm_last_q  <= s_rd.last;
        end
        if (!sf_v_q && (!sl_v_q || (s_rd.gen < sl_gen_q))) begin
          sl_idx_q <= sidx_q;
          sl_gen_q <= s_rd.gen;
        end
        if (started && upd) begin
          c_best_q  <= s_rd.gen;
          c_first_q <= s_rd.first;
        end
      end
      if (spend_q && !s_rd.valid && !sf_v_q) begin
        sf_idx_q <= sidx_q;
      end
      if (s_walk_done) begin
        if (!c_any_q || !c_have_q) begin
          res_code_q  <= c_any_q ? MATCH_UNKNOWN : MATCH_NO_RECORD;
          res_gen_q   <= '0;
          res_since_q <= '0;
          res_chg_q   <= 1'b0;
        end else begin
          res_gen_q   <= c_best_q;
          res_since_q <= c_first_q;
          res_code_q  <= (c_best_q == gen_q) ? MATCH_CURRENT : MATCH_SUPERSEDED;
          res_chg_q   <= (c_best_q != gen_q);
        end
      end
    end
  end

  assign busy_o               = (state_q != S_IDLE);
  assign cfg_ready_o          = (state_q == S_IDLE) && !start_i;
  assign result_valid_o       = (state_q == S_RES);
  assign match_code_o         = res_code_q;
  assign current_generation_o = res_gen_q;
  assign active_since_o       = res_since_q;
  assign gen_superseded_o     = res_chg_q;
  assign tracked_count_o      = res_cnt_q;

`ifndef SYNTHESIS
  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CW'(ENTITY_SLOTS)) && (cnt_q[1] <= CW'(ENTITY_SLOTS)))
    else $error("entity count beyond table size");

  a_res_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (gen_superseded_o == (match_code_o == MATCH_SUPERSEDED)))
    else $error("changed flag disagrees with match code");
`endif

endmodule

@@ sv/gir_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gir_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
